/* hw/rtl/assert_macros.svh */
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/ebt_pkg.sv */
package ebt_pkg;

  localparam int NUM_ENC = 5;
  localparam int CH_W    = 3;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_REVERSE   = 2'd0;
  localparam logic [1:0] CFG_POLL_IVL  = 2'd1;
  localparam logic [1:0] CFG_STEP_AGE  = 2'd2;

  localparam logic [15:0] POLL_IVL_RST = 16'd100;
  localparam logic [15:0] STEP_AGE_RST = 16'd1000;
  localparam logic [14:0] DUR_MAX      = 15'h7fff;

  typedef enum logic [1:0] {
    OP_PIN   = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_UP       = 3'd1,
    KIND_DOWN     = 3'd2,
    KIND_PRESSED  = 3'd3,
    KIND_LONG     = 3'd4,
    KIND_RELEASED = 3'd5
  } ev_kind_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] int_flags;
    logic [15:0] pin_capture;
    logic [2:0]  encoder_index;
    logic [31:0] now_ms;
    logic [31:0] long_press_ms;
    logic [7:0]  boost;
  } in_item_t;

  typedef struct packed {
    ev_kind_t           event_kind;
    logic [14:0]        duration_ms;
    logic signed [15:0] total_count;
    logic signed [15:0] last_count;
  } out_item_t;

  typedef struct packed {
    logic        reverse_mode;
    logic [15:0] poll_interval_ms;
    logic [15:0] step_max_age_ms;
  } cfg_t;

endpackage

/* hw/rtl/ebt_boost.sv */
module ebt_boost (
  input  logic [15:0] raw,
  input  logic [7:0]  boost,
  output logic [15:0] scaled
);
  import ebt_pkg::*;

  logic [15:0] mag;
  logic [15:0] mag_m1;
  logic [22:0] prod;
  logic [23:0] big;

  // Magnitude of the signed delta, then (|c|-1)*boost+1
  assign mag    = raw[15] ? (16'd0 - raw) : raw;
  assign mag_m1 = mag - 16'd1;
  assign prod   = mag_m1[14:0] * boost;
  assign big    = {1'b0, prod} + 24'd1;

  // Restore sign and saturate to the 16-bit signed range
  always_comb begin
    if (boost <= 8'd1 || raw == 16'd0) begin
      scaled = raw;
    end else if (!raw[15]) begin
      scaled = (big > 24'd32767) ? 16'h7fff : big[15:0];
    end else begin
      scaled = (big >= 24'd32768) ? 16'h8000 : (16'd0 - big[15:0]);
    end
  end

endmodule

/* hw/rtl/ebt_core.sv */
module ebt_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               exec,
  input  ebt_pkg::in_item_t  item,
  input  ebt_pkg::cfg_t      cfg,
  output ebt_pkg::out_item_t res
);
  import ebt_pkg::*;

  // Per-channel state
  logic [15:0] cnt_r  [NUM_ENC];
  logic [15:0] snap_r [NUM_ENC];
  logic [15:0] ld_r   [NUM_ENC];
  logic [31:0] lst_r  [NUM_ENC];
  logic [31:0] lrt_r  [NUM_ENC];
  logic [31:0] pt_r   [NUM_ENC];
  logic        bd_r   [NUM_ENC];
  logic        pr_r   [NUM_ENC];
  logic        lpf_r  [NUM_ENC];

  logic [15:0] cnt_nxt  [NUM_ENC];
  logic [15:0] snap_nxt [NUM_ENC];
  logic [15:0] ld_nxt   [NUM_ENC];
  logic [31:0] lst_nxt  [NUM_ENC];
  logic [31:0] lrt_nxt  [NUM_ENC];
  logic [31:0] pt_nxt   [NUM_ENC];
  logic        bd_nxt   [NUM_ENC];
  logic        pr_nxt   [NUM_ENC];
  logic        lpf_nxt  [NUM_ENC];

  logic             chan_ok;
  logic [CH_W-1:0]  sel;
  logic [15:0]      cnt_s, snap_s, ld_s;
  logic [31:0]      lst_s, lrt_s, pt_s;
  logic             bd_s, pr_s, lpf_s;
  logic [31:0]      now;
  logic [31:0]      rep_due, age_due, long_due, elapsed;
  logic [14:0]      dur_sat;
  logic [15:0]      diff;
  logic [15:0]      boosted;
  logic [7:0]       fa, ca;

  // Select the addressed channel; out-of-range indexes read channel 0 and are gated
  assign chan_ok = (item.encoder_index < CH_W'(NUM_ENC));
  assign sel     = chan_ok ? item.encoder_index : '0;
  assign now     = item.now_ms;

  assign cnt_s  = cnt_r[sel];
  assign snap_s = snap_r[sel];
  assign ld_s   = ld_r[sel];
  assign lst_s  = lst_r[sel];
  assign lrt_s  = lrt_r[sel];
  assign pt_s   = pt_r[sel];
  assign bd_s   = bd_r[sel];
  assign pr_s   = pr_r[sel];
  assign lpf_s  = lpf_r[sel];

  // Wrapping deadlines for the poll checks
  assign rep_due  = lrt_s + {16'd0, cfg.poll_interval_ms};
  assign age_due  = lst_s + {16'd0, cfg.step_max_age_ms};
  assign long_due = pt_s + item.long_press_ms;
  assign elapsed  = now - pt_s;
  assign dur_sat  = (|elapsed[31:15]) ? DUR_MAX : elapsed[14:0];
  assign diff     = cnt_s - snap_s;

  assign fa = item.int_flags[15:8];
  assign ca = item.pin_capture[15:8];

  ebt_boost u_boost (
    .raw    (ld_s),
    .boost  (item.boost),
    .scaled (boosted)
  );

  // Next state and result for the item in flight
  always_comb begin
    logic     pa, pb;
    logic     pr_n, lpf_n;
    ev_kind_t kind;
    for (int i = 0; i < NUM_ENC; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      snap_nxt[i] = snap_r[i];
      ld_nxt[i]   = ld_r[i];
      lst_nxt[i]  = lst_r[i];
      lrt_nxt[i]  = lrt_r[i];
      pt_nxt[i]   = pt_r[i];
      bd_nxt[i]   = bd_r[i];
      pr_nxt[i]   = pr_r[i];
      lpf_nxt[i]  = lpf_r[i];
    end
    res  = '0;
    kind = KIND_NONE;
    pr_n = pr_s;
    lpf_n = lpf_s;
    pa = 1'b0;
    pb = 1'b0;

    unique case (item.op)
      OP_PIN: begin
        // Quadrature pairs on port A for the first four encoders
        for (int b = 0; b < NUM_ENC - 1; b++) begin
          pa = ca[2*b];
          pb = ca[2*b+1];
          if (fa[2*b]) begin
            if (cfg.reverse_mode) begin
              if (pa) begin
                cnt_nxt[b] = pb ? cnt_r[b] - 16'd1 : cnt_r[b] + 16'd1;
                lst_nxt[b] = now;
              end
            end else if (!pb) begin
              cnt_nxt[b] = pa ? cnt_r[b] + 16'd1 : cnt_r[b] - 16'd1;
              lst_nxt[b] = now;
            end
          end
        end
        // Fifth encoder has fixed pins on port B
        if (item.int_flags[5] && item.pin_capture[5]) begin
          cnt_nxt[NUM_ENC-1] = item.pin_capture[6] ? cnt_r[NUM_ENC-1] - 16'd1
                                                   : cnt_r[NUM_ENC-1] + 16'd1;
          lst_nxt[NUM_ENC-1] = now;
        end
        // Buttons: low level is a press
        for (int b = 0; b < NUM_ENC; b++) begin
          if (item.int_flags[b]) begin
            if (!item.pin_capture[b]) begin
              pt_nxt[b] = now;
              bd_nxt[b] = 1'b1;
            end else begin
              bd_nxt[b] = 1'b0;
            end
          end
        end
      end

      OP_POLL: begin
        if (chan_ok && rep_due <= now) begin
          if (snap_s != cnt_s) begin
            snap_nxt[sel] = cnt_s;
            if (!(age_due <= now)) begin
              ld_nxt[sel] = diff;
              kind = diff[15] ? KIND_DOWN : KIND_UP;
            end else begin
              ld_nxt[sel] = 16'd0;
            end
          end
          if (kind == KIND_NONE) begin
            if (bd_s) begin
              if (!pr_s) begin
                pr_n  = 1'b1;
                lpf_n = 1'b0;
                kind  = KIND_PRESSED;
              end
              if (!lpf_n && item.long_press_ms != 32'd0 && long_due <= now) begin
                lpf_n = 1'b1;
                kind  = KIND_LONG;
                res.duration_ms = dur_sat;
              end
            end else if (pr_s) begin
              pr_n = 1'b0;
              if (!lpf_s) begin
                kind = KIND_RELEASED;
                res.duration_ms = dur_sat;
              end
            end
            pr_nxt[sel]  = pr_n;
            lpf_nxt[sel] = lpf_n;
          end
          if (kind != KIND_NONE) begin
            lrt_nxt[sel] = now;
          end
        end
        res.event_kind = kind;
      end

      OP_CLEAR: begin
        if (chan_ok) begin
          lst_nxt[sel] = 32'd0;
          lrt_nxt[sel] = 32'd0;
          ld_nxt[sel]  = 16'd0;
          bd_nxt[sel]  = 1'b0;
          pr_nxt[sel]  = 1'b0;
        end
      end

      OP_READ: begin
        if (chan_ok) begin
          res.total_count = $signed(cnt_s);
          res.last_count  = $signed(boosted);
        end
      end

      default: begin
      end
    endcase
  end

  // Commit state when the item leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENC; i++) begin
        cnt_r[i]  <= '0;
        snap_r[i] <= '0;
        ld_r[i]   <= '0;
        lst_r[i]  <= '0;
        lrt_r[i]  <= '0;
        bd_r[i]   <= 1'b0;
        pr_r[i]   <= 1'b0;
        lpf_r[i]  <= 1'b0;
      end
    end else if (exec) begin
      for (int i = 0; i < NUM_ENC; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        snap_r[i] <= snap_nxt[i];
        ld_r[i]   <= ld_nxt[i];
        lst_r[i]  <= lst_nxt[i];
        lrt_r[i]  <= lrt_nxt[i];
        bd_r[i]   <= bd_nxt[i];
        pr_r[i]   <= pr_nxt[i];
        lpf_r[i]  <= lpf_nxt[i];
      end
    end
  end

  // Press timestamps are written before any read
  always_ff @(posedge clk) begin
    if (exec) begin
      for (int i = 0; i < NUM_ENC; i++) begin
        pt_r[i] <= pt_nxt[i];
      end
    end
  end

endmodule

/* hw/rtl/encoder_button_event_tracker_top.sv */
// Encoder and button event tracker for five channels. One item is taken per
// clock cycle while the result is not stalled. The item passes from the input
// register to the result register, and a stall keeps it in the input register;
// out_valid rises when its result is loaded. The channel state is updated in
// that same step, so the next item already sees the effects of the previous
// one. Every item returns exactly one result: pin events, clears and polls
// that report nothing carry event_kind none, and total_count and last_count
// are nonzero only for a read-counts item. The throughput is one item per
// cycle whenever out_ready is high. A stalled result holds the input register,
// and in_ready drops only when both stages are full and out_ready is low.
// Configuration writes take effect at the next edge and belong while the block
// is idle. No clearing pass follows reset.
module encoder_button_event_tracker_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ebt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import ebt_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg_r;
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t res;
  logic      advance;
  logic      stalled;
  logic      dur_kind;
  logic      has_event;
  logic      cnt_zero;

  // Move the stage forward when the result register is free or drains
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_mode     <= 1'b0;
      cfg_r.poll_interval_ms <= POLL_IVL_RST;
      cfg_r.step_max_age_ms  <= STEP_AGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REVERSE:  cfg_r.reverse_mode     <= cfg_wdata[0];
        CFG_POLL_IVL: cfg_r.poll_interval_ms <= cfg_wdata;
        CFG_STEP_AGE: cfg_r.step_max_age_ms  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  ebt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (in_valid_r && advance),
    .item  (in_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Terms for the checks below
  assign stalled   = in_valid_r && !advance;
  assign dur_kind  = out_data.event_kind == KIND_LONG || out_data.event_kind == KIND_RELEASED;
  assign has_event = out_data.event_kind != KIND_NONE;
  assign cnt_zero  = out_data.total_count == 16'sd0 && out_data.last_count == 16'sd0;

  // Input stage backs up only behind a stalled result
  `ASSERT_CLK(a_ready_low_full, !in_ready |-> stalled, "in_ready low without a stall")
  // A stalled input stage keeps its item
  `ASSERT_CLK(a_in_hold, stalled |=> (in_valid_r && $stable(in_r)), "stalled item lost")
  // Only long press and release carry a duration
  `ASSERT_NEVER(a_dur_kind, out_valid && out_data.duration_ms != 15'd0 && !dur_kind, "stray duration")
  // Events and counts never share a result
  `ASSERT_NEVER(a_event_no_counts, out_valid && has_event && !cnt_zero, "counts on an event")

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebt_pkg::*;

  // Expected-result tracker: mirrors the five encoder and button channels
  class tracker_scoreboard;
    bit          rev;
    logic [15:0] poll_ivl;
    logic [15:0] step_age;
    logic [15:0] steps      [NUM_ENC];
    logic [15:0] snap       [NUM_ENC];
    logic [15:0] delta      [NUM_ENC];
    logic [31:0] step_t     [NUM_ENC];
    logic [31:0] report_t   [NUM_ENC];
    logic [31:0] press_t    [NUM_ENC];
    bit          held       [NUM_ENC];
    bit          reported   [NUM_ENC];
    bit          long_fired [NUM_ENC];
    out_item_t   expected_q [$];
    int          mismatches;

    function void clear_state();
      rev      = 1'b0;
      poll_ivl = POLL_IVL_RST;
      step_age = STEP_AGE_RST;
      for (int i = 0; i < NUM_ENC; i++) begin
        steps[i]      = '0;
        snap[i]       = '0;
        delta[i]      = '0;
        step_t[i]     = '0;
        report_t[i]   = '0;
        press_t[i]    = '0;
        held[i]       = 1'b0;
        reported[i]   = 1'b0;
        long_fired[i] = 1'b0;
      end
      expected_q.delete();
      mismatches = 0;
    endfunction

    function void set_regs(bit r, logic [15:0] ivl, logic [15:0] age);
      rev      = r;
      poll_ivl = ivl;
      step_age = age;
    endfunction

    // Wrapping deadline test: (t + d) mod 2^32 <= stamp
    function bit elapsed(logic [31:0] t, logic [31:0] d, logic [31:0] stamp);
      logic [31:0] sum;
      sum = t + d;
      return sum <= stamp;
    endfunction

    function void step_channel(int e, bit dn, logic [31:0] stamp);
      steps[e]  = dn ? steps[e] - 16'd1 : steps[e] + 16'd1;
      step_t[e] = stamp;
    endfunction

    function logic [14:0] clamp_duration(logic [31:0] d);
      return (d > 32'd32767) ? DUR_MAX : d[14:0];
    endfunction

    // Scale the last delta by the boost factor, saturating to 16-bit signed
    function logic [15:0] boosted_delta(logic [15:0] raw, logic [7:0] scale);
      int unsigned mag;
      bit          neg;
      if (scale <= 8'd1 || raw == 16'd0) return raw;
      neg = raw[15];
      mag = neg ? (32'h10000 - raw) : raw;
      mag = (mag - 1) * scale + 1;
      if (!neg) return (mag > 32767) ? 16'h7fff : mag[15:0];
      if (mag >= 32768) return 16'h8000;
      return 16'(32'h10000 - mag);
    endfunction

    function out_item_t predict_result(in_item_t it);
      out_item_t   res;
      ev_kind_t    kind;
      logic [7:0]  fa;
      logic [7:0]  ca;
      logic [31:0] stamp;
      int          ch;
      bit          pa;
      bit          pb;
      res   = '0;
      kind  = KIND_NONE;
      stamp = it.now_ms;
      ch    = it.encoder_index;
      if (it.op == OP_PIN) begin
        fa = it.int_flags[15:8];
        ca = it.pin_capture[15:8];
        // Port A encoders, pin roles depend on reverse mode
        for (int b = 0; b < 4; b++) begin
          if (fa[2*b]) begin
            pa = ca[2*b];
            pb = ca[2*b+1];
            if (rev) begin
              if (pa) step_channel(b, pb, stamp);
            end else if (!pb) begin
              step_channel(b, !pa, stamp);
            end
          end
        end
        // Fixed fifth encoder
        if (it.int_flags[5] && it.pin_capture[5]) step_channel(4, it.pin_capture[6], stamp);
        // Buttons: low level means pressed
        for (int b = 0; b < NUM_ENC; b++) begin
          if (it.int_flags[b]) begin
            if (!it.pin_capture[b]) begin
              press_t[b] = stamp;
              held[b]    = 1'b1;
            end else begin
              held[b] = 1'b0;
            end
          end
        end
      end else if (ch < NUM_ENC) begin
        case (it.op)
          OP_POLL: begin
            if (elapsed(report_t[ch], poll_ivl, stamp)) begin
              if (snap[ch] != steps[ch]) begin
                if (!elapsed(step_t[ch], step_age, stamp)) delta[ch] = steps[ch] - snap[ch];
                else delta[ch] = '0;
                snap[ch] = steps[ch];
                if (delta[ch] != 16'd0) kind = delta[ch][15] ? KIND_DOWN : KIND_UP;
              end
              // Rotation wins; otherwise look at the button
              if (kind == KIND_NONE) begin
                if (held[ch]) begin
                  if (!reported[ch]) begin
                    reported[ch]   = 1'b1;
                    long_fired[ch] = 1'b0;
                    kind           = KIND_PRESSED;
                  end
                  if (!long_fired[ch] && it.long_press_ms != 32'd0 &&
                      elapsed(press_t[ch], it.long_press_ms, stamp)) begin
                    long_fired[ch]  = 1'b1;
                    kind            = KIND_LONG;
                    res.duration_ms = clamp_duration(stamp - press_t[ch]);
                  end
                end else if (reported[ch]) begin
                  reported[ch] = 1'b0;
                  if (!long_fired[ch]) begin
                    kind            = KIND_RELEASED;
                    res.duration_ms = clamp_duration(stamp - press_t[ch]);
                  end
                end
              end
              if (kind != KIND_NONE) report_t[ch] = stamp;
            end
          end
          OP_CLEAR: begin
            step_t[ch]   = '0;
            report_t[ch] = '0;
            delta[ch]    = '0;
            held[ch]     = 1'b0;
            reported[ch] = 1'b0;
          end
          default: begin
            res.total_count = steps[ch];
            res.last_count  = boosted_delta(delta[ch], it.boost);
          end
        endcase
      end
      res.event_kind = kind;
      return res;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(predict_result(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d dur %0d total %0d last %0d",
                   got.event_kind, got.duration_ms, got.total_count, got.last_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.event_kind !== want.event_kind || got.duration_ms !== want.duration_ms ||
          got.total_count !== want.total_count || got.last_count !== want.last_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch (exp/act): kind %0d/%0d dur %0d/%0d total %0d/%0d last %0d/%0d",
                   want.event_kind, got.event_kind, want.duration_ms, got.duration_ms,
                   want.total_count, got.total_count, want.last_count, got.last_count);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_REVERSE;
  logic [15:0] cfg_wdata = '0;

  tracker_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_off_req  = 1'b0;
  int          accepted_items = 0;
  logic [31:0] clock_ms = '0;

  bit          phase_rev [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [15:0] phase_ivl [6] = '{16'd100, 16'd0, 16'hFFFF, 16'd20, 16'd0, 16'd5};
  logic [15:0] phase_age [6] = '{16'd1000, 16'hFFFF, 16'd0, 16'd300, 16'd0, 16'd2000};

  encoder_button_event_tracker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Result side: random back-pressure, long hold-off on request, check every item
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_off_req) begin
        hold_left    = 400;
        hold_off_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t make_item(op_t op, logic [15:0] fl, logic [15:0] cp,
                                         logic [2:0] idx, logic [31:0] stamp,
                                         logic [31:0] lp, logic [7:0] scale);
    in_item_t it;
    it.op            = op;
    it.int_flags     = fl;
    it.pin_capture   = cp;
    it.encoder_index = idx;
    it.now_ms        = stamp;
    it.long_press_ms = lp;
    it.boost         = scale;
    return it;
  endfunction

  function automatic logic [31:0] pick_hold_ms();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 32'd0;
    if (r < 80) return $urandom_range(1, 3000);
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_channel();
    return ($urandom_range(99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [15:0] sparse_noise();
    return ($urandom_range(99) < 20) ? 16'($urandom) : 16'h0000;
  endfunction

  // Offer one item after a random gap, hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    accepted_items++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input bit rev, input logic [15:0] ivl, input logic [15:0] age);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REVERSE;
    cfg_wdata <= {15'($urandom), rev};
    @(posedge clk);
    cfg_index <= CFG_POLL_IVL;
    cfg_wdata <= ivl;
    @(posedge clk);
    cfg_index <= CFG_STEP_AGE;
    cfg_wdata <= age;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(rev, ivl, age);
  endtask

  // Turn one encoder n steps in one direction, then poll it and maybe read it
  task automatic rotate_channel(input int e, input bit dn, input int n);
    logic [15:0] fl;
    logic [15:0] cp;
    for (int k = 0; k < n; k++) begin
      fl = sparse_noise();
      cp = 16'($urandom);
      if (e < 4) begin
        fl[8 + 2*e] = 1'b1;
        if (sb.rev) begin
          cp[8 + 2*e] = 1'b1;
          cp[9 + 2*e] = dn;
        end else begin
          cp[8 + 2*e] = !dn;
          cp[9 + 2*e] = 1'b0;
        end
      end else begin
        fl[5] = 1'b1;
        cp[5] = 1'b1;
        cp[6] = dn;
      end
      clock_ms += $urandom_range(0, 40);
      send_item(make_item(OP_PIN, fl, cp, pick_channel(), clock_ms, pick_hold_ms(),
                          8'($urandom)));
    end
    clock_ms += (n > 8) ? $urandom_range(0, 10) : $urandom_range(0, 1500);
    send_item(make_item(OP_POLL, 16'($urandom), 16'($urandom), 3'(e), clock_ms,
                        pick_hold_ms(), 8'($urandom)));
    if ($urandom_range(1) == 1 || n > 8)
      send_item(make_item(OP_READ, 16'($urandom), 16'($urandom), 3'(e), clock_ms,
                          pick_hold_ms(), (n > 8) ? 8'hFF : 8'($urandom)));
  endtask

  initial begin : stimulus
    logic [15:0] fl;
    logic [15:0] cp;
    logic [15:0] ivl;
    logic [15:0] age;
    int          start_count;
    int          r;
    int          ch;
    sb = new;
    sb.clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 86;

    // Directed, reset configuration
    send_item(make_item(OP_READ,  16'h0000, 16'h0000, 3'd0, 32'd0,    32'd0, 8'd0));
    send_item(make_item(OP_PIN,   16'hFFFF, 16'h0000, 3'd0, 32'd10,   32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd0, 32'd200,  32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd0, 32'd350,  32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd0, 32'd2000, 32'd1000, 8'd0));
    send_item(make_item(OP_PIN,   16'h0001, 16'h0001, 3'd0, 32'd2100, 32'd0, 8'd0));
    // release after a long press stays silent
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd0, 32'd2500, 32'd0, 8'd0));
    // stale rotation, button reports in the same poll
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd1, 32'd2600, 32'd0, 8'd0));
    send_item(make_item(OP_PIN,   16'hFF20, 16'h5560, 3'd0, 32'd2800, 32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd4, 32'd2900, 32'd0, 8'd0));
    send_item(make_item(OP_READ,  16'h0000, 16'h0000, 3'd4, 32'd2900, 32'd0, 8'hFF));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd2, 32'd3000, 32'd0, 8'd0));
    // press and long press in one poll
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd3, 32'd3000, 32'd1, 8'd0));
    send_item(make_item(OP_CLEAR, 16'h0000, 16'h0000, 3'd1, 32'd3100, 32'd0, 8'd0));
    // out-of-range channel indexes
    send_item(make_item(OP_POLL,  16'hFFFF, 16'hFFFF, 3'd7, 32'd3100, 32'd0, 8'd0));
    send_item(make_item(OP_READ,  16'h0000, 16'h0000, 3'd6, 32'd3100, 32'd0, 8'd9));
    send_item(make_item(OP_PIN,   16'h0004, 16'h0004, 3'd0, 32'd3200, 32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd2, 32'd3300, 32'd0, 8'd0));
    drain();

    // Directed, reverse mode with zero poll interval and widest age window
    program_regs(1'b1, 16'd0, 16'hFFFF);
    send_item(make_item(OP_PIN,   16'hFF04, 16'hFF00, 3'd0, 32'd4000, 32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd2, 32'd4000, 32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd2, 32'd4000, 32'd0, 8'd0));
    send_item(make_item(OP_PIN,   16'h0004, 16'h0004, 3'd0, 32'd4000, 32'd0, 8'd0));
    // release with zero duration
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd2, 32'd4000, 32'd0, 8'd0));
    send_item(make_item(OP_PIN,   16'hFF00, 16'h5500, 3'd0, 32'd4001, 32'd0, 8'd0));
    send_item(make_item(OP_POLL,  16'h0000, 16'h0000, 3'd0, 32'd4001, 32'hFFFFFFFF, 8'd0));
    send_item(make_item(OP_READ,  16'h0000, 16'h0000, 3'd0, 32'd4001, 32'd0, 8'hFF));
    drain();

    clock_ms = 32'd5000;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 86;
        recv_idle_pct = 25;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ivl = phase_ivl[p];
      age = phase_age[p];
      if (p == 4) begin
        ivl = 16'($urandom_range(0, 500));
        age = 16'($urandom_range(200, 5000));
      end
      program_regs(phase_rev[p], ivl, age);
      if (p == 0) hold_off_req <= 1'b1;
      // long spins drive the boosted delta into saturation
      if (p == 1) rotate_channel($urandom_range(0, 4), 1'b0, 140);
      if (p == 3) rotate_channel($urandom_range(0, 4), 1'b1, 140);
      start_count = accepted_items;
      while (accepted_items - start_count < 85) begin
        r = $urandom_range(99);
        if (r < 35) begin
          rotate_channel($urandom_range(0, 4), 1'($urandom_range(0, 1)),
                         $urandom_range(1, 4));
        end else if (r < 70) begin
          // press, hold over a few polls, release, poll again
          ch = $urandom_range(0, 4);
          fl = sparse_noise();
          cp = 16'($urandom);
          fl[ch] = 1'b1;
          cp[ch] = 1'b0;
          clock_ms += $urandom_range(0, 200);
          send_item(make_item(OP_PIN, fl, cp, pick_channel(), clock_ms, pick_hold_ms(),
                              8'($urandom)));
          repeat ($urandom_range(1, 4)) begin
            clock_ms += ($urandom_range(99) < 75) ? $urandom_range(0, 600)
                                                  : $urandom_range(0, 40000);
            send_item(make_item(OP_POLL, 16'($urandom), 16'($urandom), 3'(ch), clock_ms,
                                pick_hold_ms(), 8'($urandom)));
          end
          fl = sparse_noise();
          cp = 16'($urandom);
          fl[ch] = 1'b1;
          cp[ch] = 1'b1;
          clock_ms += $urandom_range(0, 600);
          send_item(make_item(OP_PIN, fl, cp, pick_channel(), clock_ms, pick_hold_ms(),
                              8'($urandom)));
          repeat ($urandom_range(1, 2)) begin
            clock_ms += $urandom_range(0, 600);
            send_item(make_item(OP_POLL, 16'($urandom), 16'($urandom), 3'(ch), clock_ms,
                                pick_hold_ms(), 8'($urandom)));
          end
        end else begin
          // unstructured items, sometimes with a jump in time
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(99) < 40) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, 300);
            send_item(make_item(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                                3'($urandom_range(0, 7)), clock_ms, pick_hold_ms(),
                                8'($urandom)));
          end
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
